/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication assertion failed");

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/ldf_pkg.sv */
// ---------------------------------------------------------------------------
// ldf_pkg
// Types and constants shared by the length-prefix deframer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldf_pkg;

    // Field and register widths.
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Message header is four bytes, least significant first.
    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned HCOUNT_W     = 2;
    localparam logic [HCOUNT_W-1:0] HEADER_LAST = HCOUNT_W'(HEADER_BYTES - 1);

    // Reset value of the maximum length register.
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'h0010_0000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMING_ENABLE = 2'd1;

    // Deframer phase.
    typedef enum logic [1:0] {
        PHASE_HEADER  = 2'd0,
        PHASE_PAYLOAD = 2'd1,
        PHASE_HALTED  = 2'd2
    } phase_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // An item held in the input register.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } ldf_item_t;

endpackage

/* src/ldf_in_stage.sv */
// ---------------------------------------------------------------------------
// ldf_in_stage
// Input register: holds one received byte until the deframer core takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldf_in_stage
    import ldf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_data_byte,
    output ldf_item_t         item,
    input  logic              take
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic              accept;

    // The register is free when empty or when its item leaves this cycle.
    assign s_ready = !valid_reg || take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

/* src/ldf_core.sv */
// ---------------------------------------------------------------------------
// ldf_core
// Framing state, configuration registers and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldf_core
    import ldf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  ldf_item_t              item,
    output logic                   take,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [DATA_W-1:0]      m_payload_byte,
    output logic                   m_last
);

    logic [LEN_W-1:0]    max_length_reg;
    logic                framing_enable_reg;

    phase_t              phase_reg, phase_next;
    logic [HCOUNT_W-1:0] header_count_reg, header_count_next;
    logic [LEN_W-1:0]    payload_length_reg, payload_length_next;
    logic [LEN_W-1:0]    bytes_left_reg, bytes_left_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg;
    logic [DATA_W-1:0]   out_byte_reg;
    logic                out_last_reg;

    logic                res_valid;
    kind_t               res_kind;
    logic [DATA_W-1:0]   res_byte;
    logic                res_last;
    logic [LEN_W-1:0]    assembled;
    logic                is_last;

    // An item moves on when the result register is empty or being emptied.
    assign take = item.valid && (!out_valid_reg || m_ready);

    // Header byte placed at its little-endian position.
    assign assembled = payload_length_reg
                     | (LEN_W'(item.data) << {header_count_reg, 3'b000});
    assign is_last   = (bytes_left_reg <= LEN_W'(1));

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg     <= MAX_LENGTH_RESET;
            framing_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_LENGTH:     max_length_reg     <= cfg_wdata[LEN_W-1:0];
                REG_FRAMING_ENABLE: framing_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Next state and result for the item being taken.
    always_comb begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        payload_length_next = payload_length_reg;
        bytes_left_next     = bytes_left_reg;
        res_valid           = 1'b0;
        res_kind            = KIND_BYTE;
        res_byte            = '0;
        res_last            = 1'b0;

        if (take && framing_enable_reg) begin
            unique case (phase_reg)
                PHASE_HEADER: begin
                    payload_length_next = assembled;
                    if (header_count_reg != HEADER_LAST) begin
                        header_count_next = header_count_reg + HCOUNT_W'(1);
                    end else begin
                        header_count_next = '0;
                        if (assembled > max_length_reg) begin
                            phase_next = PHASE_HALTED;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERROR;
                        end else if (assembled == '0) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_EMPTY;
                            res_last  = 1'b1;
                        end else begin
                            bytes_left_next     = assembled;
                            payload_length_next = '0;
                            phase_next          = PHASE_PAYLOAD;
                        end
                    end
                end
                PHASE_PAYLOAD: begin
                    if (is_last) begin
                        bytes_left_next     = '0;
                        phase_next          = PHASE_HEADER;
                        payload_length_next = '0;
                        header_count_next   = '0;
                    end else begin
                        bytes_left_next = bytes_left_reg - LEN_W'(1);
                    end
                    res_valid = 1'b1;
                    res_kind  = KIND_BYTE;
                    res_byte  = item.data;
                    res_last  = is_last;
                end
                // Halted, and the unused phase code, drop the byte.
                default: ;
            endcase
        end
    end

    // Result register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PHASE_HEADER;
            header_count_reg   <= '0;
            payload_length_reg <= '0;
            bytes_left_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            payload_length_reg <= payload_length_next;
            bytes_left_reg     <= bytes_left_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Result payload is loaded only when a new result is produced.
    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_payload_byte = out_byte_reg;
    assign m_last         = out_last_reg;

endmodule

/* src/length_prefix_deframer.sv */
// ---------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into messages with a four-byte little-endian length.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one stream byte per item. Each message is a 4-byte
//   little-endian length header followed by that many payload bytes.
//   The m_ channel gives one result per payload byte (kind payload, last set
//   on the final byte), one empty-message result for a zero length, or one
//   error result for a length above max_length, after which the block drops
//   every byte until reset. Header bytes give no result.
//   Configuration: index 0 is max_length, index 1 is framing_enable; with
//   framing disabled bytes are dropped and the framing state is held.
//   An accepted byte passes through the input register and then the result
//   register before its result is valid. Throughput is one item per cycle
//   while the receiver is ready, set by the single state update in the core.
//   Reset clears the framing state, sets max_length to 1 MiB and disables
//   framing. When the receiver stalls, the result register holds its item
//   and the input register takes one more byte before s_ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefix_deframer
    import ldf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [DATA_W-1:0]      s_data_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [DATA_W-1:0]      m_payload_byte,
    output logic                   m_last
);

    ldf_item_t item;
    logic      take;

    // Input register.
    ldf_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .item        (item),
        .take        (take)
    );

    // Framing state and result register.
    ldf_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item           (item),
        .take           (take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

    // Backpressure only when the input register is full behind a stalled result.
    `ASSERT_IMPLY(a_ready_low_only_when_stalled, aclk, aresetn, !s_ready, item.valid && m_valid && !m_ready)
    // An empty-message result carries the last flag and no payload.
    `ASSERT_IMPLY(a_empty_form, aclk, aresetn, m_valid && (m_kind == KIND_EMPTY), m_last && (m_payload_byte == '0))
    // Once the error result is delivered the block stays silent.
    `ASSERT_NEXT(a_silent_after_error, aclk, aresetn, m_valid && m_ready && (m_kind == KIND_ERROR), !m_valid)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefix deframer. A byte driver feeds
// stream bytes from a queue and a monitor checks every result against a
// predictor that tracks header assembly, payload counting and the halted
// state. Register writes happen only while the block is quiet. Random idle
// bursts on both channels are switched off towards the end. The run ends on
// a length-too-long error, after which every byte must be dropped.
// ---------------------------------------------------------------------------

module tb_top;
    import ldf_pkg::*;

    // Register indexes with no register behind them.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int unsigned ITEM_TARGET = 1420;
    localparam int unsigned QUIET_FROM  = 1200;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] payload;
        logic              last;
    } deframe_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [DATA_W-1:0]      s_data_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [KIND_W-1:0]      m_kind;
    logic [DATA_W-1:0]      m_payload_byte;
    logic                   m_last;

    // Bytes waiting to be driven and results waiting to be seen.
    logic [DATA_W-1:0] stream_q[$];
    deframe_result_t   expected_q[$];

    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned items_sent = 0;
    int unsigned fail_cnt = 0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    logic        in_fire = 1'b0;
    logic        idle_on = 1'b1;

    // Predictor copy of the registers and framing state.
    logic [LEN_W-1:0]    max_len = MAX_LENGTH_RESET;
    logic                framing_on = 1'b0;
    phase_t              rx_phase = PHASE_HEADER;
    logic [HCOUNT_W-1:0] hdr_count = '0;
    logic [LEN_W-1:0]    hdr_len = '0;
    logic [LEN_W-1:0]    bytes_left = '0;

    length_prefix_deframer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

    // Clock, 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Advances the framing state by one accepted byte and records any result.
    function automatic void deframe_byte(input logic [DATA_W-1:0] b);
        deframe_result_t r;
        if (framing_on) begin
            case (rx_phase)
                PHASE_HEADER: begin
                    hdr_len = hdr_len | (LEN_W'(b) << (8 * hdr_count));
                    if (hdr_count != HEADER_LAST) begin
                        hdr_count = hdr_count + 1'b1;
                    end else begin
                        hdr_count = '0;
                        if (hdr_len > max_len) begin
                            rx_phase = PHASE_HALTED;
                            r = '{kind: KIND_ERROR, payload: '0, last: 1'b0};
                            expected_q.push_back(r);
                        end else if (hdr_len == '0) begin
                            r = '{kind: KIND_EMPTY, payload: '0, last: 1'b1};
                            expected_q.push_back(r);
                        end else begin
                            bytes_left = hdr_len;
                            hdr_len = '0;
                            rx_phase = PHASE_PAYLOAD;
                        end
                    end
                end
                PHASE_PAYLOAD: begin
                    if (bytes_left <= 1) begin
                        bytes_left = '0;
                        hdr_len = '0;
                        hdr_count = '0;
                        rx_phase = PHASE_HEADER;
                        r = '{kind: KIND_BYTE, payload: b, last: 1'b1};
                    end else begin
                        bytes_left = bytes_left - 1'b1;
                        r = '{kind: KIND_BYTE, payload: b, last: 1'b0};
                    end
                    expected_q.push_back(r);
                end
                default: begin
                    // Halted: the byte is dropped.
                end
            endcase
        end
    endfunction

    // Byte driver: presents the next queued item once the previous one has gone.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                s_valid <= 1'b0;
            end else if (stream_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 15);
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data_byte <= stream_q.pop_front();
            end
        end
    end

    // Result receiver readiness, with random stall bursts.
    always @(negedge aclk) begin
        if (out_stall > 0) begin
            out_stall = out_stall - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            out_stall = $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: checks results against the oldest expectation, then predicts
    // from the byte accepted at the same edge.
    always @(posedge aclk) begin : result_monitor
        deframe_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d payload %0d last %0d",
                           m_kind, m_payload_byte, m_last);
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        fail_cnt++;
                    end
                    if (m_payload_byte !== want.payload) begin
                        $error("payload_byte: expected %0d, got %0d",
                               want.payload, m_payload_byte);
                        fail_cnt++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_data_byte);
                accepted_cnt++;
            end
            in_fire <= s_valid && s_ready;
        end else begin
            in_fire <= 1'b0;
        end
    end

    task automatic queue_byte(input logic [DATA_W-1:0] b);
        stream_q.push_back(b);
        pushed_cnt++;
        if (framing_on) begin
            items_sent++;
        end
    endtask

    task automatic queue_header(input logic [LEN_W-1:0] len);
        for (int i = 0; i < HEADER_BYTES; i++) begin
            queue_byte(len[8 * i +: 8]);
        end
    endtask

    task automatic queue_message(input int unsigned len);
        queue_header(len);
        repeat (len) queue_byte(DATA_W'($urandom));
    endtask

    // Waits until every byte is taken, every result seen and the pipeline empty.
    task automatic wait_quiet();
        while (accepted_cnt != pushed_cnt || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MAX_LENGTH) begin
            max_len = val;
        end else if (idx == REG_FRAMING_ENABLE) begin
            framing_on = val[0];
        end
    endtask

    // A message interrupted by a spell of disabled framing with noise bytes.
    task automatic queue_split_message(input int unsigned len);
        logic [DATA_W-1:0] msg_bytes[$];
        logic [LEN_W-1:0]  hdr;
        int unsigned       cut;
        hdr = len;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            msg_bytes.push_back(hdr[8 * i +: 8]);
        end
        repeat (len) msg_bytes.push_back(DATA_W'($urandom));
        cut = $urandom_range(1, msg_bytes.size() - 1);
        for (int i = 0; i < cut; i++) begin
            queue_byte(msg_bytes[i]);
        end
        wait_quiet();
        write_reg(REG_FRAMING_ENABLE, '0);
        repeat ($urandom_range(1, 6)) queue_byte(DATA_W'($urandom));
        wait_quiet();
        write_reg(REG_FRAMING_ENABLE, CFG_DATA_W'(1));
        for (int i = cut; i < msg_bytes.size(); i++) begin
            queue_byte(msg_bytes[i]);
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        logic [LEN_W-1:0] lim;
        int unsigned      cap;
        int unsigned      len;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Framing is off after reset, so these bytes are dropped.
        repeat (3) queue_byte(DATA_W'($urandom));
        wait_quiet();

        // Spare indexes are ignored, and only bit 0 of the enable counts.
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        write_reg(REG_FRAMING_ENABLE, 32'hFFFF_FFFE);
        repeat (2) queue_byte(DATA_W'($urandom));
        wait_quiet();

        // Directed messages with the reset maximum: empty, one byte, extremes.
        write_reg(REG_FRAMING_ENABLE, CFG_DATA_W'(1));
        queue_header('0);
        queue_header(32'd1);
        queue_byte(8'hFF);
        queue_header(32'd2);
        queue_byte(8'h00);
        queue_byte(8'h80);
        queue_header(32'd3);
        queue_byte(8'h7F);
        queue_byte(8'h01);
        queue_byte(8'hFE);
        wait_quiet();

        // Random phases, each under its own maximum length.
        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: lim = '0;
                1: lim = '1;
                2: lim = $urandom_range(1, 40);
                3: lim = MAX_LENGTH_RESET;
                4: lim = 32'h7FFF_FFFF;
                default: lim = $urandom_range(1, 8);
            endcase
            write_reg(REG_MAX_LENGTH, lim);
            if ($urandom_range(0, 7) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_FRAMING_ENABLE, $urandom | CFG_DATA_W'(1));
            end
            // Lengths never exceed the current maximum, so the block only
            // halts in the closing phase.
            if (lim < 24) begin
                cap = lim;
            end else begin
                cap = (($urandom_range(0, 9) == 0) && (lim >= 64)) ? 64 : 24;
            end
            repeat ($urandom_range(4, 12)) begin
                len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
                if ($urandom_range(0, 5) == 0) begin
                    queue_split_message(len);
                end else begin
                    queue_message(len);
                end
            end
            wait_quiet();
        end

        // Closing phase: a header with the top bit set must be refused as
        // too long, and every later byte dropped.
        idle_on = 1'b0;
        write_reg(REG_MAX_LENGTH, MAX_LENGTH_RESET);
        queue_message(3);
        queue_header(32'h8000_0000);
        repeat (8) queue_byte(DATA_W'($urandom));
        wait_quiet();

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/ldf_pkg.sv
src/ldf_in_stage.sv
src/ldf_core.sv
src/length_prefix_deframer.sv
bench/tb_top.sv
